// ----- design/ascii_cell_quantizer_assert.svh -----
// Assertion macros for the ASCII cell quantizer.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef ASCII_CELL_QUANTIZER_ASSERT_SVH
`define ASCII_CELL_QUANTIZER_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define ACQ_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication.
`define ACQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ----- design/acq_pkg.sv -----
// Shared types, constants and functions of the ASCII cell quantizer.
// No dependencies.
package acq_pkg;
    localparam int MAX_COLUMNS_DEF     = 256;
    localparam int LEVELS_DEF          = 16;
    localparam int MAX_CELL_PIXELS_DEF = 64;

    localparam logic [6:0] CHAR_NEWLINE = 7'd10;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CELL_WIDTH   = 3'd2,
        REG_CELL_HEIGHT  = 3'd3,
        REG_COLUMN_COUNT = 3'd4,
        REG_ROW_COUNT    = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT_CHAR,
        ST_EMIT_NL
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic take_pixel;   // latch input pixel
        logic accum;        // write sum, compute completion, advance position
        logic div_start;    // start the divider
        logic out_char;     // load output with ramp char
        logic out_nl;       // load output with newline
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic cell_done;    // pixel completes a cell
        logic last_col;     // that cell is the last column
        logic div_busy;
    } t_stat;

    function automatic logic [6:0] ramp_char(input logic [3:0] idx);
        logic [6:0] c;
        unique case (idx)
            4'd0:  c = 7'h20; 4'd1:  c = 7'h2E; 4'd2:  c = 7'h27; 4'd3:  c = 7'h2D;
            4'd4:  c = 7'h3A; 4'd5:  c = 7'h3B; 4'd6:  c = 7'h3D; 4'd7:  c = 7'h2B;
            4'd8:  c = 7'h2A; 4'd9:  c = 7'h78; 4'd10: c = 7'h58; 4'd11: c = 7'h25;
            4'd12: c = 7'h23; 4'd13: c = 7'h38; 4'd14: c = 7'h26;
            default: c = 7'h40;
        endcase
        return c;
    endfunction
endpackage

// ----- design/acq_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module acq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ----- design/acq_ctrl.sv -----
// Controller state machine of the ASCII cell quantizer.
// Depends on acq_pkg.
module acq_ctrl import acq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_fire,
    input  logic   i_out_free,   // output register empty
    input  t_stat  i_stat,
    output t_cmd   o_cmd,
    output logic   o_in_ready,
    output t_state o_state
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.take_pixel = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_ACCUM;
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state = ST_IDLE;
                if (i_stat.cell_done) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_EMIT_CHAR;
                end
            end
            ST_EMIT_CHAR: begin
                if (i_out_free) begin
                    o_cmd.out_char = 1'b1;
                    n_state = i_stat.last_col ? ST_EMIT_NL : ST_IDLE;
                end
            end
            ST_EMIT_NL: begin
                if (i_out_free) begin
                    o_cmd.out_nl = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.div_start = (r_state == ST_ACCUM) && i_stat.cell_done;
    end

    assign o_state = r_state;
endmodule

// ----- design/acq_datapath.sv -----
// Datapath: position counters, column-sum store, divider and output register.
// Depends on acq_pkg and acq_ram.
module acq_datapath import acq_pkg::*; #(
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF,
    parameter int LEVELS          = LEVELS_DEF,
    parameter int MAX_CELL_PIXELS = MAX_CELL_PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [7:0]  i_pixel_level,
    input  logic        i_frame_start,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_out_take,     // output transfer this cycle
    output logic        o_out_valid,
    output logic [6:0]  o_char_code,
    output logic        o_frame_end,
    output logic        o_last
);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LW  = $clog2(LEVELS);
    localparam int MXQ = MAX_CELL_PIXELS * 256;
    // Dividend < 2*(L-1)*2^20 + 255*2^24 fits in 36 bits with margin.
    localparam int NW  = 40;
    localparam int DW  = 32;   // 510*area with area <= 64*64
    localparam int QW  = 6;    // quotient kept only up to 63 then capped
    // ramp index scaling by reciprocal multiplication, exact for idx*15 < 2^20/(L-1)
    localparam int RCP_SHIFT = 20;
    localparam logic [31:0] RCP = 32'(((1 << RCP_SHIFT) + LEVELS - 2) / (LEVELS - 1));

    // configuration
    logic [12:0] r_fw, r_fh, r_rows;
    logic [14:0] r_cw, r_ch;
    logic [8:0]  r_cols;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 13'd800; r_fh <= 13'd600; r_cw <= 15'd2560; r_ch <= 15'd4096;
            r_cols <= 9'd80; r_rows <= 13'd37;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_fw   <= i_cfg_data[12:0];
                REG_FRAME_HEIGHT: r_fh   <= i_cfg_data[12:0];
                REG_CELL_WIDTH:   r_cw   <= i_cfg_data;
                REG_CELL_HEIGHT:  r_ch   <= i_cfg_data;
                REG_COLUMN_COUNT: r_cols <= i_cfg_data[8:0];
                REG_ROW_COUNT:    r_rows <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [12:0] fw, fh, rows;
    logic [20:0] cw, ch;
    logic [CW-1:0] cols;
    always_comb begin
        fw   = (r_fw == 0) ? 13'd1 : (r_fw > 13'd4096 ? 13'd4096 : r_fw);
        fh   = (r_fh == 0) ? 13'd1 : (r_fh > 13'd4096 ? 13'd4096 : r_fh);
        rows = (r_rows == 0) ? 13'd1 : (r_rows > 13'd4096 ? 13'd4096 : r_rows);
        cw   = (r_cw < 15'd256) ? 21'd256 :
               ({6'd0, r_cw} > 21'(MXQ) ? 21'(MXQ) : {6'd0, r_cw});
        ch   = (r_ch < 15'd256) ? 21'd256 :
               ({6'd0, r_ch} > 21'(MXQ) ? 21'(MXQ) : {6'd0, r_ch});
        if (r_cols == 0) cols = CW'(1);
        else if (32'(r_cols) > 32'(MAX_COLUMNS)) cols = CW'(MAX_COLUMNS);
        else cols = CW'(r_cols);
    end

    // position state
    logic [11:0] r_px, r_py, r_xs, r_ys, r_crow;
    logic [CW-1:0] r_ccol;
    logic [20:0] r_xe, r_ye;
    logic [7:0] r_lvl;
    logic       r_fs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pixel) begin
            r_lvl <= i_pixel_level;
        end
    end

    // effective position after optional frame restart
    logic [11:0] px, py, xs, ys, crow;
    logic [CW-1:0] ccol;
    logic [20:0] xe, ye;
    always_comb begin
        if (r_fs) begin
            px = '0; py = '0; xs = '0; ys = '0; crow = '0; ccol = '0; xe = cw; ye = ch;
        end else begin
            px = r_px; py = r_py; xs = r_xs; ys = r_ys; crow = r_crow; ccol = r_ccol;
            xe = r_xe; ye = r_ye;
        end
    end

    logic in_region, first_px, done;
    logic [12:0] x_end, y_end;
    logic [AW-1:0] addr;
    always_comb begin
        in_region = (ccol < cols) && ({1'b0, crow} < rows);
        x_end     = xe[20:8];
        y_end     = ye[20:8];
        first_px  = (py == ys) && (px == xs);
        done      = in_region && ({1'b0, px} + 13'd1 == x_end)
                              && ({1'b0, py} + 13'd1 == y_end);
        addr      = AW'(ccol);
    end

    // column store; read issued in the READ state, which follows take_pixel
    logic [19:0] rd_sum, sum;
    acq_ram #(.WIDTH(20), .DEPTH(1 << AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accum && in_region),
        .i_waddr(addr),
        .i_wdata(sum),
        .i_raddr(addr),
        .o_rdata(rd_sum)
    );
    assign sum = first_px ? {12'd0, r_lvl} : rd_sum + {12'd0, r_lvl};

    logic [12:0] ny;
    assign ny = {1'b0, py} + 13'd1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0; r_py <= '0; r_xs <= '0; r_ys <= '0; r_crow <= '0; r_ccol <= '0;
            r_xe <= cw; r_ye <= ch; r_fs <= 1'b0;
        end else if (i_cmd.accum) begin
            r_fs <= 1'b0;
            r_py <= py; r_ys <= ys; r_crow <= crow; r_ye <= ye;
            if ({1'b0, px} + 13'd1 >= fw) begin
                r_px <= '0; r_ccol <= '0; r_xs <= '0; r_xe <= cw;
                if (ny >= fh) begin
                    r_py <= '0; r_crow <= '0; r_ys <= '0; r_ye <= ch;
                end else begin
                    r_py <= ny[11:0];
                    if ({1'b0, crow} < rows && ny >= y_end) begin
                        r_crow <= crow + 12'd1;
                        r_ys   <= y_end[11:0];
                        r_ye   <= ye + ch;
                    end
                end
            end else begin
                r_px <= px + 12'd1;
                r_ccol <= ccol; r_xs <= xs; r_xe <= xe;
                if (ccol < cols && {1'b0, px} + 13'd1 >= x_end) begin
                    r_ccol <= ccol + CW'(1);
                    r_xs   <= x_end[11:0];
                    r_xe   <= xe + cw;
                end
            end
        end else if (i_cmd.take_pixel) begin
            r_fs <= i_frame_start;
        end
    end

    // cell result info
    logic r_last_col, r_last_row, r_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else if (i_cmd.accum) begin
            r_done     <= done;
            r_last_col <= (ccol + CW'(1) == cols);
            r_last_row <= ({1'b0, crow} + 13'd1 == rows);
        end
    end

    // restoring divider: q = (2(L-1)sum + 255a) / (510a), one bit per cycle
    // area <= 64*64 -> divisor < 2^21; dividend < 2^36
    logic [12:0] aw_, ah_;
    logic [25:0] area;
    assign aw_  = x_end - {1'b0, xs};
    assign ah_  = y_end - {1'b0, ys};
    assign area = (aw_ * ah_ == 0) ? 26'd1 : 26'(aw_ * ah_);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;
    logic [2:0]    r_bit;
    logic          r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_num  <= NW'(36'(2 * (LEVELS - 1)) * {16'd0, sum}) + NW'(36'd255 * {10'd0, area});
            r_den  <= DW'(36'd510 * {10'd0, area});
            r_q    <= '0;
            r_bit  <= 3'(QW - 1);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            // compare at 2^bit weight: quotient < 64 when capped at 63
            if ((NW'(r_num) >= (NW'(r_den) << r_bit))) begin
                r_num <= r_num - (NW'(r_den) << r_bit);
                r_q[r_bit] <= 1'b1;
            end
            if (r_bit == 0) r_busy <= 1'b0;
            else r_bit <= r_bit - 3'd1;
        end
    end

    // the quotient can exceed 63 only when above full scale; the upper-bit
    // shortfall is caught by the leftover remainder check
    logic [LW-1:0] idx;
    logic [3:0]    ridx;
    logic [31:0]   ridx_prod;
    logic over;
    always_comb begin
        over      = (r_num >= NW'(r_den)) || (32'(r_q) > LEVELS - 1);
        idx       = over ? LW'(LEVELS - 1) : LW'(r_q);
        ridx_prod = (32'(idx) * 32'd15) * RCP;
        ridx      = 4'(ridx_prod >> RCP_SHIFT);
    end

    // output register
    logic r_ov;
    logic [6:0] r_cc;
    logic r_fe, r_lst;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_char) begin
            r_ov <= 1'b1; r_cc <= ramp_char(ridx); r_fe <= 1'b0; r_lst <= !r_last_col;
        end else if (i_cmd.out_nl) begin
            r_ov <= 1'b1; r_cc <= CHAR_NEWLINE; r_fe <= r_last_row; r_lst <= 1'b1;
        end else if (i_out_take) begin
            r_ov <= 1'b0;
        end
    end

    assign o_stat.cell_done = done;
    assign o_stat.last_col  = r_last_col;
    assign o_stat.div_busy  = r_busy || i_cmd.div_start || !r_done;
    assign o_out_valid = r_ov;
    assign o_char_code = r_cc;
    assign o_frame_end = r_fe;
    assign o_last      = r_lst;
endmodule

// ----- design/ascii_cell_quantizer.sv -----
// Top level of the ASCII cell quantizer: stream ports and assertions.
// Depends on acq_pkg, acq_ctrl, acq_datapath, ascii_cell_quantizer_assert.svh.
//
// Usage:
//  - Pixels enter on the s_axis group: tdata[7:0] = pixel_level,
//    tuser = frame_start (resets position to (0,0) before this pixel).
//  - Characters leave on m_axis: tdata[6:0] = char_code, tuser = frame_end,
//    tlast = last result of the causing pixel.
//  - Registers are written on the cfg channel (index 0..5); the user must do
//    so only while idle, as the block itself does not enforce it.
//  - A pixel that completes no cell passes accept, store read, accumulate. A
//    cell-completing pixel adds bit-serial division (six quotient bits), the
//    character and, after the last column, a newline, which waits for the
//    character to drain; the store read step serves the registered read port.
//  - One pixel is in work at a time; a stalled receiver holds the output
//    register and the controller waits before loading the next result.
//  - After reset, registers take their defaults and position is (0,0);
//    the store needs no clearing since every entry is written first.
`include "ascii_cell_quantizer_assert.svh"
module ascii_cell_quantizer import acq_pkg::*; #(
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF,
    parameter int LEVELS          = LEVELS_DEF,
    parameter int MAX_CELL_PIXELS = MAX_CELL_PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_level
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic        m_axis_tuser,   // [0] frame_end
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    t_cmd   cmd;
    t_stat  stat;
    t_state state;
    logic   in_fire, out_take, out_free;
    logic [6:0] cc;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;
    // take the next result only once the register drains
    assign out_free = !m_axis_tvalid;
    assign o_cfg_ready = 1'b1;

    acq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire), .i_out_free(out_free),
        .i_stat(stat), .o_cmd(cmd), .o_in_ready(s_axis_tready), .o_state(state)
    );

    acq_datapath #(
        .MAX_COLUMNS(MAX_COLUMNS), .LEVELS(LEVELS), .MAX_CELL_PIXELS(MAX_CELL_PIXELS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_pixel_level(s_axis_tdata), .i_frame_start(s_axis_tuser),
        .i_cfg_we(i_cfg_valid), .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_out_take(out_take), .o_out_valid(m_axis_tvalid),
        .o_char_code(cc), .o_frame_end(m_axis_tuser), .o_last(m_axis_tlast)
    );
    assign m_axis_tdata = {1'b0, cc};

    `ACQ_ASSERT_IMPL(a_no_accept_busy, s_axis_tready, state == ST_IDLE,
        "input accepted outside idle")
    `ACQ_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `ACQ_ASSERT_IMPL(a_fe_on_nl, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == {1'b0, CHAR_NEWLINE} && m_axis_tlast, "frame_end off newline")
endmodule
